@@ rtl/uartbq_pkg.sv @@
package uartbq_pkg;

    localparam int RING_DEPTH = 128;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_OUT_W  = 7;
    // wide enough for a full count and for the seven reported bits
    localparam int CALC_W     = (PTR_W + 1 > CNT_OUT_W) ? PTR_W + 1 : CNT_OUT_W;

    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [CALC_W-1:0]    t_calc;
    typedef logic [CNT_OUT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        MODE_SEND    = 3'd0,
        MODE_READ    = 3'd1,
        MODE_LINE_RX = 3'd2,
        MODE_TX_TICK = 3'd3,
        MODE_FLUSH   = 3'd4
    } t_mode;

    // event outcome waiting for the ring read data
    typedef struct packed {
        logic       accepted;
        logic       read_valid;
        logic       line_valid;
        logic       line_from_ring;
        logic [7:0] line_byte;
        logic       rx_dropped;
        t_cnt       rx_count;
        t_cnt       tx_free;
        logic       tx_busy;
    } t_s1;

    typedef struct packed {
        logic       accepted;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       line_valid;
        logic [7:0] line_byte;
        logic       rx_dropped;
        t_cnt       rx_count;
        t_cnt       tx_free;
        logic       tx_busy;
    } t_result;

    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr n;
        n = (p == t_ptr'(RING_DEPTH - 1)) ? '0 : t_ptr'(p + 1'b1);
        return n;
    endfunction

    function automatic t_calc ring_count(input t_ptr w, input t_ptr r);
        t_calc c;
        if (w >= r) begin
            c = t_calc'(w) - t_calc'(r);
        end else begin
            c = t_calc'(w) + t_calc'(RING_DEPTH) - t_calc'(r);
        end
        return c;
    endfunction

endpackage

@@ rtl/uartbq_ring_ram.sv @@
module uartbq_ring_ram #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/uart_buffered_byte_queues.sv @@
// byte queues between a host and a serial line: a receive ring and a transmit
// ring in two synchronous memories, each holding up to RING_DEPTH-1 bytes
// input channel: i_valid / o_stall carry one event word (i_mode, i_data_byte);
// mode 0 host send, 1 host read, 2 byte from the line, 3 transmitter-empty
// tick, 4 flush of the receive ring, other codes only report the counts
// output channel: o_valid / i_stall carry one result word per event, with the
// flags of the event and the receive count, transmit free space and busy flag
// an accepted event goes through the read stage, for the ring memory read, and
// then the output register before o_valid
// with i_stall low, throughput is one event per cycle; pointers live in
// registers and each event does one read or write at most on one ring memory
// when i_stall holds the output register, the event behind it waits in the
// read stage and o_stall rises until the output is taken
// reset clears the pointers, the busy flag and both valid stages; the ring
// memories are not cleared and no clearing pass is needed
module uart_buffered_byte_queues (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_accepted,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic       o_line_valid,
    output logic [7:0] o_line_byte,
    output logic       o_rx_dropped,
    output logic [6:0] o_rx_count,
    output logic [6:0] o_tx_free,
    output logic       o_tx_busy
);

    import uartbq_pkg::*;

    t_ptr    r_rx_wp, r_rx_rp, r_tx_wp, r_tx_rp;
    t_ptr    n_rx_wp, n_rx_rp, n_tx_wp, n_tx_rp;
    logic    r_tx_active, n_tx_active;
    logic    r_s1_valid;
    t_s1     r_s1, n_s1;
    logic    r_out_valid;
    t_result r_out;

    logic    accept_in;
    logic    s1_adv;
    logic    rx_we, rx_re, tx_we, tx_re;
    t_calc   rx_cnt_full, tx_free_full;
    logic [7:0] rx_rdata, tx_rdata;

    assign s1_adv    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s1_adv;
    assign accept_in = i_valid && !o_stall;

    // event decode: pointer updates and ring accesses
    always_comb begin
        n_rx_wp     = r_rx_wp;
        n_rx_rp     = r_rx_rp;
        n_tx_wp     = r_tx_wp;
        n_tx_rp     = r_tx_rp;
        n_tx_active = r_tx_active;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        n_s1        = '0;
        unique case (t_mode'(i_mode))
            MODE_SEND: begin
                if (r_tx_wp == r_tx_rp && !r_tx_active) begin
                    // ring empty and line idle: straight to the line
                    n_s1.line_valid = 1'b1;
                    n_s1.line_byte  = i_data_byte;
                    n_s1.accepted   = 1'b1;
                    n_tx_active     = 1'b1;
                end else if (ptr_next(r_tx_wp) != r_tx_rp) begin
                    tx_we         = 1'b1;
                    n_tx_wp       = ptr_next(r_tx_wp);
                    n_s1.accepted = 1'b1;
                end
            end
            MODE_READ: begin
                if (r_rx_wp != r_rx_rp) begin
                    rx_re           = 1'b1;
                    n_s1.read_valid = 1'b1;
                    n_rx_rp         = ptr_next(r_rx_rp);
                end
            end
            MODE_LINE_RX: begin
                if (ptr_next(r_rx_wp) != r_rx_rp) begin
                    rx_we   = 1'b1;
                    n_rx_wp = ptr_next(r_rx_wp);
                end else begin
                    n_s1.rx_dropped = 1'b1;
                end
            end
            MODE_TX_TICK: begin
                if (r_tx_active) begin
                    if (r_tx_wp == r_tx_rp) begin
                        n_tx_active = 1'b0;
                    end else begin
                        tx_re               = 1'b1;
                        n_s1.line_valid     = 1'b1;
                        n_s1.line_from_ring = 1'b1;
                        n_tx_rp             = ptr_next(r_tx_rp);
                    end
                end
            end
            MODE_FLUSH: begin
                n_rx_wp = '0;
                n_rx_rp = '0;
            end
            default: begin
            end
        endcase
        rx_cnt_full  = ring_count(n_rx_wp, n_rx_rp);
        tx_free_full = t_calc'(RING_DEPTH - 1) - ring_count(n_tx_wp, n_tx_rp);
        n_s1.rx_count = rx_cnt_full[CNT_OUT_W-1:0];
        n_s1.tx_free  = tx_free_full[CNT_OUT_W-1:0];
        n_s1.tx_busy  = n_tx_active;
    end

    uartbq_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (8)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept_in && rx_we),
        .i_wr_addr (r_rx_wp),
        .i_wr_data (i_data_byte),
        .i_rd_en   (accept_in && rx_re),
        .i_rd_addr (r_rx_rp),
        .o_rd_data (rx_rdata)
    );

    uartbq_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (8)
    ) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept_in && tx_we),
        .i_wr_addr (r_tx_wp),
        .i_wr_data (i_data_byte),
        .i_rd_en   (accept_in && tx_re),
        .i_rd_addr (r_tx_rp),
        .o_rd_data (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wp     <= '0;
            r_rx_rp     <= '0;
            r_tx_wp     <= '0;
            r_tx_rp     <= '0;
            r_tx_active <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_rx_wp     <= n_rx_wp;
                r_rx_rp     <= n_rx_rp;
                r_tx_wp     <= n_tx_wp;
                r_tx_rp     <= n_tx_rp;
                r_tx_active <= n_tx_active;
            end
            if (accept_in) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.accepted   <= r_s1.accepted;
            r_out.read_valid <= r_s1.read_valid;
            r_out.read_byte  <= r_s1.read_valid ? rx_rdata : 8'h00;
            r_out.line_valid <= r_s1.line_valid;
            r_out.line_byte  <= r_s1.line_from_ring ? tx_rdata : r_s1.line_byte;
            r_out.rx_dropped <= r_s1.rx_dropped;
            r_out.rx_count   <= r_s1.rx_count;
            r_out.tx_free    <= r_s1.tx_free;
            r_out.tx_busy    <= r_s1.tx_busy;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_accepted   = r_out.accepted;
    assign o_read_valid = r_out.read_valid;
    assign o_read_byte  = r_out.read_byte;
    assign o_line_valid = r_out.line_valid;
    assign o_line_byte  = r_out.line_byte;
    assign o_rx_dropped = r_out.rx_dropped;
    assign o_rx_count   = r_out.rx_count;
    assign o_tx_free    = r_out.tx_free;
    assign o_tx_busy    = r_out.tx_busy;

endmodule
